// File: sv/lzrle_pkg.sv
// Shared widths, code masks and defaults of the LZ/RLE stream decompressor.
package lzrle_pkg;

   localparam int BYTE_W     = 8;
   localparam int COUNT_W    = 13;
   localparam int TOTAL_W    = 24;
   localparam int HDR_W      = 4;
   localparam int COPY_CNT_W = 5;

   localparam int DEF_HISTORY_DEPTH = 8192;
   localparam int DEF_LENGTH_BITS   = 24;

   localparam logic [HDR_W-1:0]   HEADER_LEN = 4'hC;
   localparam logic [COUNT_W-1:0] FILL_MAX   = 13'd4099;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 24'hFFFFFF;

   // code byte decoding
   localparam logic [BYTE_W-1:0] CODE_END       = 8'h00;
   localparam logic [BYTE_W-1:0] CODE_COPY      = 8'h80;
   localparam logic [BYTE_W-1:0] CODE_FILL      = 8'h40;
   localparam logic [BYTE_W-1:0] CODE_FILL_LONG = 8'h10;
   localparam logic [BYTE_W-1:0] CODE_LIT_LONG  = 8'h20;
   localparam logic [BYTE_W-1:0] EXT_MASK       = 8'hE0;
   localparam logic [BYTE_W-1:0] EXT_CODE       = 8'h60;

   localparam logic [COUNT_W-1:0]    MIN_RUN  = 13'd4;
   localparam logic [COPY_CNT_W-1:0] MIN_COPY = 5'd4;

endpackage

// File: sv/lz_rle_stream_decompressor_unit.sv
// Top level of the LZ/RLE stream decompressor with its history ring.
//
//   channel  direction  handshake                    payload
//   req      in         req_valid / req_ready        req_in_byte
//   rsp      out        rsp_valid / rsp_ready        rsp_out_byte, rsp_repeat_count,
//                                                    rsp_stream_end, rsp_total_length
//   csr      in         csr_write_enable (no wait)   csr_write_data (skip_header)
//
// Header, code, length and literal bytes are taken back to back. A back-reference copies
// each byte by a ring read (C_COPY_RD), then a ring write and result (C_COPY_WR), as the
// ring read is registered; the write waits on a full result register. A fill of n bytes
// gives its result with its fill byte, then holds input for n-1 ring writes, one a cycle.
// Reset: after reset a clearing pass writes zero to all HISTORY_DEPTH ring entries,
// one a cycle, while no item is taken; csr writes are taken throughout.
// Stalls: a full result register stalls bytes that give a result right away, and copy writes.
module lz_rle_stream_decompressor_unit
   import lzrle_pkg::*;
#(
   parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
   parameter int LENGTH_BITS   = DEF_LENGTH_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [BYTE_W-1:0]  req_in_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [BYTE_W-1:0]  rsp_out_byte,
   output logic [COUNT_W-1:0] rsp_repeat_count,
   output logic               rsp_stream_end,
   output logic [TOTAL_W-1:0] rsp_total_length,
   input  logic               csr_write_enable,
   input  logic               csr_write_data
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int LB = LENGTH_BITS;

   // sequencer states
   localparam logic [2:0] C_CLEAR   = 3'd0;
   localparam logic [2:0] C_RUN     = 3'd1;
   localparam logic [2:0] C_COPY_RD = 3'd2;
   localparam logic [2:0] C_COPY_WR = 3'd3;
   localparam logic [2:0] C_FILL    = 3'd4;

   // decode phases
   localparam logic [3:0] PH_START     = 4'd0;
   localparam logic [3:0] PH_HEADER    = 4'd1;
   localparam logic [3:0] PH_CODE      = 4'd2;
   localparam logic [3:0] PH_COPY_OFF  = 4'd3;
   localparam logic [3:0] PH_FILL_LEN  = 4'd4;
   localparam logic [3:0] PH_FILL_BYTE = 4'd5;
   localparam logic [3:0] PH_LIT_LEN   = 4'd6;
   localparam logic [3:0] PH_LIT_DATA  = 4'd7;

   localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);

   logic [2:0]            ctl_ff, ctl_in;
   logic [3:0]            phase_ff, phase_in;
   logic [AW-1:0]         wp_ff, wp_in;
   logic [AW-1:0]         cp_ff, cp_in;
   logic [AW-1:0]         clr_addr_ff, clr_addr_in;
   logic [COUNT_W-1:0]    pend_ff, pend_in;
   logic [BYTE_W-1:0]     code_ff, code_in;
   logic                  after_copy_ff, after_copy_in;
   logic [HDR_W-1:0]      hdr_left_ff, hdr_left_in;
   logic [LB-1:0]         len_ff, len_in;
   logic [COPY_CNT_W-1:0] copy_left_ff, copy_left_in;
   logic [COUNT_W-1:0]    fill_left_ff, fill_left_in;
   logic [BYTE_W-1:0]     fill_val_ff, fill_val_in;
   logic                  skip_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]     out_byte_ff;
   logic [COUNT_W-1:0]    out_rep_ff;
   logic                  out_end_ff;
   logic [TOTAL_W-1:0]    out_total_ff;

   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr;
   logic [BYTE_W-1:0]     wr_data, rd_data;

   logic                  emit;
   logic [BYTE_W-1:0]     emit_byte;
   logic [COUNT_W-1:0]    emit_rep;
   logic                  emit_end;
   logic [TOTAL_W-1:0]    emit_total;

   logic                  out_free, emit_now, req_accept, take_code;
   logic                  is_ext;
   logic [AW-1:0]         wp_inc, cp_inc, clr_inc;
   logic [AW:0]           cp_sum, cp_wrap;
   logic [LB:0]           len_sum1, len_sumn;
   logic [LB-1:0]         len_plus1, len_plusn;
   logic [31:0]           len_wide;
   logic [TOTAL_W-1:0]    total_sat;

   lzrle_ring #(
      .DEPTH (HISTORY_DEPTH),
      .AW    (AW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (cp_ff),
      .rd_data (rd_data)
   );

   // ring pointer arithmetic
   assign wp_inc  = (wp_ff == LAST_ADDR) ? '0 : wp_ff + 1'b1;
   assign cp_inc  = (cp_ff == LAST_ADDR) ? '0 : cp_ff + 1'b1;
   assign clr_inc = clr_addr_ff + 1'b1;

   // copy start: (wp + depth - offset) mod depth, sum stays below twice the depth
   assign cp_sum  = {1'b0, wp_ff} + (AW+1)'(HISTORY_DEPTH)
                    - (AW+1)'({code_ff[4:0], req_in_byte});
   assign cp_wrap = (cp_sum >= (AW+1)'(HISTORY_DEPTH)) ?
                    cp_sum - (AW+1)'(HISTORY_DEPTH) : cp_sum;

   // saturating length updates
   assign len_sum1  = {1'b0, len_ff} + (LB+1)'(1);
   assign len_sumn  = {1'b0, len_ff} + (LB+1)'(pend_ff);
   assign len_plus1 = len_sum1[LB] ? '1 : len_sum1[LB-1:0];
   assign len_plusn = len_sumn[LB] ? '1 : len_sumn[LB-1:0];
   assign len_wide  = 32'(len_ff);
   assign total_sat = (len_wide > 32'(TOTAL_MAX)) ? TOTAL_MAX : len_wide[TOTAL_W-1:0];

   assign is_ext   = ((req_in_byte & EXT_MASK) == EXT_CODE);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // bytes that hand over a result in the cycle they transfer
   always_comb begin
      emit_now = 1'b0;
      case (phase_ff)
         PH_START:     emit_now = !skip_ff && (req_in_byte == CODE_END);
         PH_CODE:      emit_now = !(after_copy_ff && is_ext) && (req_in_byte == CODE_END);
         PH_FILL_BYTE: emit_now = 1'b1;
         PH_LIT_DATA:  emit_now = 1'b1;
         default:      emit_now = 1'b0;
      endcase
   end

   assign req_ready  = (ctl_ff == C_RUN) && (out_free || !emit_now);
   assign req_accept = req_valid && req_ready;

   always_comb begin
      ctl_in        = ctl_ff;
      phase_in      = phase_ff;
      wp_in         = wp_ff;
      cp_in         = cp_ff;
      clr_addr_in   = clr_addr_ff;
      pend_in       = pend_ff;
      code_in       = code_ff;
      after_copy_in = after_copy_ff;
      hdr_left_in   = hdr_left_ff;
      len_in        = len_ff;
      copy_left_in  = copy_left_ff;
      fill_left_in  = fill_left_ff;
      fill_val_in   = fill_val_ff;
      wr_en         = 1'b0;
      wr_addr       = wp_ff;
      wr_data       = req_in_byte;
      rd_en         = 1'b0;
      emit          = 1'b0;
      emit_byte     = req_in_byte;
      emit_rep      = COUNT_W'(1);
      emit_end      = 1'b0;
      emit_total    = '0;
      take_code     = 1'b0;

      case (ctl_ff)
         C_CLEAR: begin
            // sweep zeros through the ring after reset
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_inc;
            if (clr_addr_ff == LAST_ADDR) begin
               ctl_in = C_RUN;
            end
         end

         C_RUN: begin
            if (req_accept) begin
               case (phase_ff)
                  PH_START: begin
                     if (skip_ff) begin
                        hdr_left_in = HEADER_LEN - 1'b1;
                        phase_in    = PH_HEADER;
                     end else begin
                        phase_in      = PH_CODE;
                        after_copy_in = 1'b0;
                        take_code     = 1'b1;
                     end
                  end
                  PH_HEADER: begin
                     if (hdr_left_ff != '0) begin
                        hdr_left_in = hdr_left_ff - 1'b1;
                     end
                     if (hdr_left_ff <= HDR_W'(1)) begin
                        phase_in = PH_CODE;
                     end
                  end
                  PH_CODE: begin
                     if (after_copy_ff && is_ext) begin
                        // extend the previous copy, an empty extension does nothing
                        copy_left_in = COPY_CNT_W'(req_in_byte[4:0]);
                        if (req_in_byte[4:0] != '0) begin
                           ctl_in = C_COPY_RD;
                        end
                     end else begin
                        after_copy_in = 1'b0;
                        take_code     = 1'b1;
                     end
                  end
                  PH_COPY_OFF: begin
                     cp_in         = cp_wrap[AW-1:0];
                     copy_left_in  = COPY_CNT_W'(code_ff[6:5]) + MIN_COPY;
                     phase_in      = PH_CODE;
                     after_copy_in = 1'b1;
                     ctl_in        = C_COPY_RD;
                  end
                  PH_FILL_LEN: begin
                     pend_in  = COUNT_W'({code_ff[3:0], req_in_byte}) + MIN_RUN;
                     phase_in = PH_FILL_BYTE;
                  end
                  PH_FILL_BYTE: begin
                     // one result for the run, then finish the ring writes
                     emit         = 1'b1;
                     emit_rep     = pend_ff;
                     wr_en        = 1'b1;
                     wp_in        = wp_inc;
                     len_in       = len_plusn;
                     fill_val_in  = req_in_byte;
                     fill_left_in = pend_ff - 1'b1;
                     phase_in     = PH_CODE;
                     if (pend_ff > COUNT_W'(1)) begin
                        ctl_in = C_FILL;
                     end
                  end
                  PH_LIT_LEN: begin
                     pend_in  = COUNT_W'({code_ff[4:0], req_in_byte});
                     phase_in = ({code_ff[4:0], req_in_byte} != '0) ? PH_LIT_DATA : PH_CODE;
                  end
                  PH_LIT_DATA: begin
                     emit   = 1'b1;
                     wr_en  = 1'b1;
                     wp_in  = wp_inc;
                     len_in = len_plus1;
                     if (pend_ff != '0) begin
                        pend_in = pend_ff - 1'b1;
                     end
                     if (pend_ff <= COUNT_W'(1)) begin
                        phase_in = PH_CODE;
                     end
                  end
                  default: begin
                     phase_in = PH_START;
                  end
               endcase

               if (take_code) begin
                  if (req_in_byte == CODE_END) begin
                     emit       = 1'b1;
                     emit_byte  = '0;
                     emit_rep   = '0;
                     emit_end   = 1'b1;
                     emit_total = total_sat;
                     len_in     = '0;
                     phase_in   = PH_START;
                  end else begin
                     code_in = req_in_byte;
                     if ((req_in_byte & CODE_COPY) != '0) begin
                        phase_in = PH_COPY_OFF;
                     end else if ((req_in_byte & CODE_FILL) != '0) begin
                        if ((req_in_byte & CODE_FILL_LONG) != '0) begin
                           phase_in = PH_FILL_LEN;
                        end else begin
                           pend_in  = COUNT_W'(req_in_byte[3:0]) + MIN_RUN;
                           phase_in = PH_FILL_BYTE;
                        end
                     end else if ((req_in_byte & CODE_LIT_LONG) != '0) begin
                        phase_in = PH_LIT_LEN;
                     end else begin
                        pend_in  = COUNT_W'(req_in_byte[4:0]);
                        phase_in = PH_LIT_DATA;
                     end
                  end
               end
            end
         end

         C_COPY_RD: begin
            rd_en  = 1'b1;
            cp_in  = cp_inc;
            ctl_in = C_COPY_WR;
         end

         C_COPY_WR: begin
            // hold the read byte until the result register frees up
            if (out_free) begin
               wr_en        = 1'b1;
               wr_data      = rd_data;
               wp_in        = wp_inc;
               emit         = 1'b1;
               emit_byte    = rd_data;
               len_in       = len_plus1;
               copy_left_in = copy_left_ff - 1'b1;
               ctl_in       = (copy_left_ff <= COPY_CNT_W'(1)) ? C_RUN : C_COPY_RD;
            end
         end

         C_FILL: begin
            wr_en        = 1'b1;
            wr_data      = fill_val_ff;
            wp_in        = wp_inc;
            fill_left_in = fill_left_ff - 1'b1;
            if (fill_left_ff <= COUNT_W'(1)) begin
               ctl_in = C_RUN;
            end
         end

         default: begin
            ctl_in = C_RUN;
         end
      endcase
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff        <= C_CLEAR;
         phase_ff      <= PH_START;
         wp_ff         <= '0;
         cp_ff         <= '0;
         clr_addr_ff   <= '0;
         pend_ff       <= '0;
         code_ff       <= '0;
         after_copy_ff <= 1'b0;
         hdr_left_ff   <= '0;
         len_ff        <= '0;
         copy_left_ff  <= '0;
         fill_left_ff  <= '0;
         skip_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         ctl_ff        <= ctl_in;
         phase_ff      <= phase_in;
         wp_ff         <= wp_in;
         cp_ff         <= cp_in;
         clr_addr_ff   <= clr_addr_in;
         pend_ff       <= pend_in;
         code_ff       <= code_in;
         after_copy_ff <= after_copy_in;
         hdr_left_ff   <= hdr_left_in;
         len_ff        <= len_in;
         copy_left_ff  <= copy_left_in;
         fill_left_ff  <= fill_left_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_enable) begin
            skip_ff <= csr_write_data;
         end
      end
   end

   // result payload and fill byte carry no reset
   always_ff @(posedge clock) begin
      fill_val_ff <= fill_val_in;
      if (emit) begin
         out_byte_ff  <= emit_byte;
         out_rep_ff   <= emit_rep;
         out_end_ff   <= emit_end;
         out_total_ff <= emit_total;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_repeat_count = out_rep_ff;
   assign rsp_stream_end   = out_end_ff;
   assign rsp_total_length = out_total_ff;

endmodule

// File: sv/lzrle_ring.sv
// History ring storage: one write port, one registered read port.
module lzrle_ring
   import lzrle_pkg::*;
#(
   parameter int DEPTH = DEF_HISTORY_DEPTH,
   parameter int AW    = $clog2(DEF_HISTORY_DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/lzrle_checker.sv
// Port-level checks of the decompressor results, bound to the top level.
module lzrle_checker
   import lzrle_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [BYTE_W-1:0]  rsp_out_byte,
   input logic [COUNT_W-1:0] rsp_repeat_count,
   input logic               rsp_stream_end,
   input logic [TOTAL_W-1:0] rsp_total_length
);

   // end result carries only the length
   a_end_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_end |-> rsp_out_byte == '0 && rsp_repeat_count == '0)
      else $error("end result with nonzero byte or count");

   // data results carry a count and no length
   a_data_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stream_end |-> rsp_repeat_count != '0 && rsp_total_length == '0)
      else $error("data result with zero count or nonzero length");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_repeat_count <= FILL_MAX)
      else $error("repeat count beyond longest fill");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_repeat_count) && $stable(rsp_stream_end)
         && $stable(rsp_total_length))
      else $error("stalled result changed");

endmodule

bind lz_rle_stream_decompressor_unit lzrle_checker u_lzrle_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_repeat_count (rsp_repeat_count),
   .rsp_stream_end   (rsp_stream_end),
   .rsp_total_length (rsp_total_length)
);
